// File: sv/lav_pkg.sv
`default_nettype none

package lav_pkg;

  // Fixed field widths of the request and response transactions.
  localparam int MAX_WAYS     = 16;
  localparam int DEFAULT_WAYS = 16;
  localparam int WAY_W        = 4;
  localparam int AGE_W        = 4;
  localparam int MASK_W       = 16;

  // Request type codes.
  localparam logic REQ_HIT    = 1'b0;
  localparam logic REQ_VICTIM = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lav_state_t;

  // Running best candidate handed from cell to cell during a victim scan.
  typedef struct packed {
    logic [WAY_W-1:0] idx;
    logic [AGE_W-1:0] age;
  } lav_scan_t;

  // Broadcast MRU update sent to every cell.
  typedef struct packed {
    logic             upd;
    logic [AGE_W-1:0] ref_age;
  } lav_touch_t;

endpackage

`default_nettype wire

// File: sv/lav_req_if.sv
`default_nettype none

interface lav_req_if
  import lav_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [WAY_W-1:0]  way_index;
  logic [MASK_W-1:0] valid_mask;
  logic [MASK_W-1:0] eligible_mask;

  modport source (
    output valid, req_type, way_index, valid_mask, eligible_mask,
    input  ready
  );

  modport sink (
    input  valid, req_type, way_index, valid_mask, eligible_mask,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/lav_rsp_if.sv
`default_nettype none

interface lav_rsp_if
  import lav_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WAY_W-1:0] victim_way;

  modport source (
    output valid, victim_way,
    input  ready
  );

  modport sink (
    input  valid, victim_way,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/lru_age_victim_select.sv
`default_nettype none

// Channel  Direction  Transaction payload
// -------  ---------  ---------------------------------------------------
// req      in         req_type, way_index, valid_mask, eligible_mask
// rsp      out        victim_way (one per victim request, none per hit)
//
// A hit update is applied at the edge that accepts it, and the block stays
// ready for another request. A victim request with an invalid way goes
// straight to the commit step; otherwise the age scan walks the row of
// cells one way per cycle. No new request is taken until the commit.
// A finished result waits in the output register; the block only stalls in
// its commit step while that register is still full. Reset sets ages to the
// way numbers and clears the controller state and the output valid flag.

module lru_age_victim_select
  import lav_pkg::*;
#(
  parameter int WAYS = DEFAULT_WAYS
) (
  input  wire logic clk,
  input  wire logic rst,
  lav_req_if.sink   req,
  lav_rsp_if.source rsp
);

  localparam int NWAY  = (WAYS < MAX_WAYS) ? WAYS : MAX_WAYS;
  localparam int CNT_W = $clog2(NWAY + 1);

  lav_state_t       state;
  lav_state_t       state_next;
  logic [CNT_W-1:0] scan_cnt;
  logic [NWAY-1:0]  elig_q;
  logic [WAY_W-1:0] victim_q;
  logic             rsp_valid;
  logic [WAY_W-1:0] rsp_way;

  logic             req_acc;
  logic             victim_acc;
  logic             hit_go;
  logic             commit_go;
  logic             scan_done;
  logic             inv_found;
  logic [WAY_W-1:0] inv_idx;
  logic [WAY_W-1:0] tgt;
  logic [NWAY-1:0]  hit_vec;
  logic [AGE_W-1:0] ref_age;
  lav_touch_t       touch;

  logic [AGE_W-1:0] age_arr [NWAY];
  lav_scan_t        chain   [NWAY+1];

  assign req_acc    = req.valid && req.ready;
  assign victim_acc = req_acc && (req.req_type == REQ_VICTIM);
  assign hit_go     = req_acc && (req.req_type == REQ_HIT) && (int'(req.way_index) < NWAY);
  assign commit_go  = (state == ST_COMMIT) && (!rsp_valid || rsp.ready);
  assign scan_done  = (state == ST_SCAN) && (scan_cnt == CNT_W'(NWAY));

  // Lowest-numbered invalid way among the ways that exist.
  always_comb begin
    inv_found = 1'b0;
    inv_idx   = '0;
    for (int i = NWAY - 1; i >= 0; i--) begin
      if (!req.valid_mask[i]) begin
        inv_found = 1'b1;
        inv_idx   = WAY_W'(i);
      end
    end
  end

  // Way to make MRU and the age it had before the update.
  assign tgt = hit_go ? req.way_index : victim_q;

  always_comb begin
    ref_age = '0;
    for (int i = 0; i < NWAY; i++) begin
      hit_vec[i] = (tgt == WAY_W'(i));
      if (hit_vec[i]) begin
        ref_age = ref_age | age_arr[i];
      end
    end
  end

  assign touch.upd     = hit_go || commit_go;
  assign touch.ref_age = ref_age;

  // Row of age cells; the scan candidate moves one cell per cycle.
  assign chain[0] = '0;

  for (genvar g = 0; g < NWAY; g++) begin : g_cell
    lav_age_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .touch    (touch),
      .hit      (hit_vec[g]),
      .elig     (elig_q[g]),
      .scan_in  (chain[g]),
      .scan_out (chain[g+1]),
      .age      (age_arr[g])
    );
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and input handshake.
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (victim_acc) begin
          state_next = inv_found ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Scan counter, captured eligibility and the chosen way.
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      scan_cnt <= scan_cnt + CNT_W'(1);
    end else begin
      scan_cnt <= '0;
    end
    if (victim_acc) begin
      elig_q   <= req.eligible_mask[NWAY-1:0];
      victim_q <= inv_idx;
    end else if (scan_done) begin
      victim_q <= chain[NWAY].idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      rsp_way <= victim_q;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.victim_way = rsp_way;

  // A commit always leaves the chosen way in the output register.
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit_go |=> (rsp.valid && (rsp.victim_way == $past(victim_q))))
    else $error("commit did not present the chosen way");

  // The scan never runs past the end of the row.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_cnt <= CNT_W'(NWAY)))
    else $error("scan counter overran the cell row");

  // A hit update never creates a result.
  a_hit_no_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.req_type == REQ_HIT) && !rsp.valid) |=> !rsp.valid)
    else $error("hit update produced a result");

endmodule

`default_nettype wire

// File: sv/lav_age_cell.sv
`default_nettype none

module lav_age_cell
  import lav_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lav_touch_t       touch,
  input  wire logic             hit,
  input  wire logic             elig,
  input  wire lav_scan_t        scan_in,
  output      lav_scan_t        scan_out,
  output      logic [AGE_W-1:0] age
);

  // Age of this way: the touched way becomes MRU, younger ways grow one older.
  always_ff @(posedge clk) begin
    if (rst) begin
      age <= AGE_W'(CELL_IDX);
    end else if (touch.upd) begin
      if (hit) begin
        age <= '0;
      end else if (age < touch.ref_age) begin
        age <= age + AGE_W'(1);
      end
    end
  end

  // Scan stage: replace the incoming candidate if this way is eligible and
  // strictly older, so the lowest index keeps a tie.
  always_ff @(posedge clk) begin
    if (elig && (age > scan_in.age)) begin
      scan_out.idx <= WAY_W'(CELL_IDX);
      scan_out.age <= age;
    end else begin
      scan_out <= scan_in;
    end
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`default_nettype none

import lav_pkg::*;

// One request transaction as the sender presents it.
typedef struct packed {
  logic              req_type;
  logic [WAY_W-1:0]  way_index;
  logic [MASK_W-1:0] valid_mask;
  logic [MASK_W-1:0] eligible_mask;
} lav_request_t;

// Tracks the LRU ages of the set and the victim ways still owed by the block.
class lru_victim_board;
  logic [AGE_W-1:0] way_age [MAX_WAYS];
  logic [WAY_W-1:0] victim_queue [$];
  int               errors;

  function new();
    errors = 0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_age[w] = AGE_W'(w);
    end
  endfunction

  // Make one way MRU: every younger way ages by one, the way itself goes to 0.
  function void touch_way(logic [WAY_W-1:0] way);
    logic [AGE_W-1:0] old_age;
    old_age = way_age[way];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_age[w] < old_age) begin
        way_age[w] = way_age[w] + 1'b1;
      end
    end
    way_age[way] = '0;
  endfunction

  // An invalid way wins first; otherwise the oldest eligible way with a
  // nonzero age, lowest index on a tie, and way 0 when nothing qualifies.
  function logic [WAY_W-1:0] choose_victim(logic [MASK_W-1:0] vmask,
                                           logic [MASK_W-1:0] emask);
    logic [WAY_W-1:0] pick;
    logic [AGE_W-1:0] pick_age;
    pick = '0;
    pick_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!vmask[w]) begin
        return WAY_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (emask[w] && way_age[w] > pick_age) begin
        pick = WAY_W'(w);
        pick_age = way_age[w];
      end
    end
    return pick;
  endfunction

  // Called for every accepted request transaction.
  function void note_request(lav_request_t r);
    logic [WAY_W-1:0] v;
    if (r.req_type == REQ_HIT) begin
      touch_way(r.way_index);
    end else begin
      v = choose_victim(r.valid_mask, r.eligible_mask);
      touch_way(v);
      victim_queue.push_back(v);
    end
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Called for every accepted response transaction.
  task check_victim(logic [WAY_W-1:0] got);
    logic [WAY_W-1:0] want;
    if (victim_queue.size() == 0) begin
      report($sformatf("victim_way %0d returned with no victim request pending", got));
    end else begin
      want = victim_queue.pop_front();
      if (got !== want) begin
        report($sformatf("victim_way %0d, expected %0d", got, want));
      end
    end
  endtask
endclass

module testbench;
  localparam int LIMIT        = 400000;
  localparam int RANDOM_ITEMS = 650;
  localparam int MAX_PAUSE    = 18;
  localparam int SETTLE       = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  bit   steady_flow = 1'b0;

  lru_victim_board board = new();

  lav_req_if req_ch ();
  lav_rsp_if rsp_ch ();

  lru_age_victim_select uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // Idle cycles before the next transaction; none while steady flow is on.
  function automatic int draw_pause();
    if (steady_flow) begin
      return 0;
    end
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic lav_request_t make_request(logic kind, logic [WAY_W-1:0] way,
                                                logic [MASK_W-1:0] vmask,
                                                logic [MASK_W-1:0] emask);
    lav_request_t r;
    r.req_type = kind;
    r.way_index = way;
    r.valid_mask = vmask;
    r.eligible_mask = emask;
    return r;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic push_request(lav_request_t r);
    int gap;
    gap = draw_pause();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.req_type;
    req_ch.way_index <= r.way_index;
    req_ch.valid_mask <= r.valid_mask;
    req_ch.eligible_mask <= r.eligible_mask;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(r);
  endtask

  task automatic hold_off();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (board.victim_queue.size() != 0) @(posedge clk);
  endtask

  // Random traffic, weighted toward full sets so the age scan does the work.
  task automatic push_random();
    lav_request_t r;
    int kind;
    kind = $urandom_range(0, 99);
    r.way_index = WAY_W'($urandom);
    r.eligible_mask = MASK_W'($urandom);
    r.valid_mask = MASK_W'($urandom);
    if (kind < 30) begin
      r.req_type = REQ_HIT;
    end else if (kind < 75) begin
      r.req_type = REQ_VICTIM;
      r.valid_mask = '1;
      case ($urandom_range(0, 3))
        0: r.eligible_mask = MASK_W'($urandom & $urandom & $urandom);
        1: r.eligible_mask = MASK_W'($urandom | $urandom);
        2: r.eligible_mask = MASK_W'(1) << $urandom_range(0, MAX_WAYS - 1);
        default: ;
      endcase
    end else if (kind < 90) begin
      // Mostly full set with one or two holes anywhere.
      r.req_type = REQ_VICTIM;
      r.valid_mask = ~(MASK_W'(1) << $urandom_range(0, MAX_WAYS - 1));
      if ($urandom_range(0, 1)) begin
        r.valid_mask[$urandom_range(0, MAX_WAYS - 1)] = 1'b0;
      end
    end else begin
      r.req_type = REQ_VICTIM;
    end
    push_request(r);
  endtask

  // Run limit.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_age_victim_select test failed");
    $finish;
  end

  // Response side: random stalls, then check each transaction it takes.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_pause();
      repeat (stall) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      board.check_victim(rsp_ch.victim_way);
    end
  end

  // Request side and end of run.
  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_HIT;
    req_ch.way_index = '0;
    req_ch.valid_mask = '0;
    req_ch.eligible_mask = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: mask extremes, hits at both ends, every selection case.
    push_request(make_request(REQ_VICTIM, 4'h0, 16'h0000, 16'h0000));
    push_request(make_request(REQ_VICTIM, 4'hF, 16'hFFFF, 16'hFFFF));
    push_request(make_request(REQ_HIT, 4'h0, 16'h0000, 16'h0000));
    push_request(make_request(REQ_HIT, 4'hF, 16'hFFFF, 16'hFFFF));
    push_request(make_request(REQ_VICTIM, 4'h3, 16'h7FFF, 16'h0000));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'h0000));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'h0001));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'h8000));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFE, 16'hFFFF));
    push_request(make_request(REQ_HIT, 4'h5, 16'h1234, 16'h4321));
    push_request(make_request(REQ_HIT, 4'hA, 16'hFFFF, 16'h0000));
    // The only eligible way was just made MRU, so nothing qualifies.
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'h0400));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'hFFFF));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hFFFF, 16'h7FFE));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hAAAA, 16'hFFFF));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'h5555, 16'hFFFF));
    push_request(make_request(REQ_VICTIM, 4'h0, 16'hBFFF, 16'h0000));
    push_request(make_request(REQ_HIT, 4'h7, 16'h0000, 16'hFFFF));
    push_request(make_request(REQ_HIT, 4'h7, 16'h0000, 16'hFFFF));
    push_request(make_request(REQ_VICTIM, 4'h9, 16'hFFFF, 16'h5555));
    push_request(make_request(REQ_VICTIM, 4'h6, 16'hFFFF, 16'hAAAA));
    hold_off();

    // Random part, with steady-flow stretches and one more drain midway.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) begin
        steady_flow = ($urandom_range(0, 3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) begin
        hold_off();
      end
      push_random();
    end
    steady_flow = 1'b0;
    hold_off();
    repeat (SETTLE) @(posedge clk);

    if (board.errors == 0 && board.victim_queue.size() == 0) begin
      $display("lru_age_victim_select test passed");
    end else begin
      $display("lru_age_victim_select test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
